FILE: rtl/msv_pkg.sv
// ----------------------------------------------------------------------------
// msv_pkg: shared types, constants and byte arithmetic for the score filter
// Sizes of the profile, codes of the input words and registers, and the
// structs that travel along the row of position cells.
// ----------------------------------------------------------------------------
`default_nettype none

package msv_pkg;

  localparam int MAX_POSITIONS = 256;
  localparam int ALPHABET_SIZE = 32;

  localparam int POS_W     = $clog2(MAX_POSITIONS);
  localparam int LEN_W     = $clog2(MAX_POSITIONS + 1);
  localparam int RES_IDX_W = $clog2(ALPHABET_SIZE);
  // Compare widths wide enough for both the field and the bound.
  localparam int POS_CMP_W = ((POS_W > 8) ? POS_W : 8) + 1;
  localparam int LEN_CMP_W = (LEN_W > 9) ? LEN_W : 9;
  localparam int RES_CMP_W = ((RES_IDX_W > 5) ? RES_IDX_W : 5) + 1;

  localparam logic [7:0] SAT_MAX = 8'hff;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_RESIDUE = 2'd2;

  localparam logic [2:0] CFG_MODEL_LENGTH  = 3'd0;
  localparam logic [2:0] CFG_EMISSION_BIAS = 3'd1;
  localparam logic [2:0] CFG_SCORE_BASE    = 3'd2;
  localparam logic [2:0] CFG_JB_COST       = 3'd3;
  localparam logic [2:0] CFG_BM_COST       = 3'd4;
  localparam logic [2:0] CFG_EC_COST       = 3'd5;

  // One residue step as it moves from cell to cell.
  typedef struct packed {
    logic                 valid;
    logic                 res_ok;
    logic [RES_IDX_W-1:0] res_idx;
    logic [7:0]           b;
    logic [7:0]           prev;
    logic [7:0]           emax;
  } msv_token_t;

  // Signals sent to every cell at once.
  typedef struct packed {
    logic                 load;
    logic                 clear;
    logic [RES_IDX_W-1:0] res_idx;
    logic [7:0]           pos;
    logic [7:0]           cost;
    logic [7:0]           bias;
    logic [LEN_W-1:0]     eff_len;
  } msv_bcast_t;

  function automatic logic [7:0] add_sat(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? SAT_MAX : s[7:0];
  endfunction

  function automatic logic [7:0] sub_sat(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : 8'd0;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/msv_cell.sv
// ----------------------------------------------------------------------------
// msv_cell: one profile position of the score row
// Holds the row byte and the emission costs of its position, updates the row
// byte when a residue word passes within the model length, hands the word on.
// ----------------------------------------------------------------------------
`default_nettype none

module msv_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [msv_pkg::POS_W-1:0]    cell_idx,
  input  wire  msv_pkg::msv_bcast_t    bcast,
  input  wire  msv_pkg::msv_token_t    tok_in,
  output msv_pkg::msv_token_t          tok_out
);
  import msv_pkg::*;

  logic [7:0] row_r;
  logic [7:0] col_r [ALPHABET_SIZE];
  msv_token_t tok_r;

  logic       active;
  logic       load_hit;
  logic [7:0] cost;
  logic [7:0] score;

  assign active   = LEN_W'(cell_idx) < bcast.eff_len;
  assign load_hit = bcast.load && (POS_CMP_W'(bcast.pos) == POS_CMP_W'(cell_idx));
  assign cost     = tok_in.res_ok ? col_r[tok_in.res_idx] : SAT_MAX;
  assign score    = sub_sat(add_sat(max8(tok_in.prev, tok_in.b), bcast.bias), cost);

  // Emission costs of this position; undefined until loaded.
  always_ff @(posedge clk) begin
    if (load_hit) begin
      col_r[bcast.res_idx] <= bcast.cost;
    end
  end

  // The word carries this cell's old row byte on, so the next cell sees the
  // previous row at k-1 even though this cell overwrites it now.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 8'd0;
      tok_r <= '0;
    end else begin
      if (bcast.clear) begin
        row_r <= 8'd0;
      end else if (tok_in.valid && active) begin
        row_r <= score;
      end
      tok_r.valid   <= tok_in.valid;
      tok_r.res_ok  <= tok_in.res_ok;
      tok_r.res_idx <= tok_in.res_idx;
      tok_r.b       <= tok_in.b;
      tok_r.prev    <= row_r;
      tok_r.emax    <= active ? max8(tok_in.emax, score) : tok_in.emax;
    end
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

FILE: rtl/msv_profile_score_filter_unit.sv
// ----------------------------------------------------------------------------
// msv_profile_score_filter_unit: ungapped profile score filter, byte scores
// A residue word's result is formed by the walk through the cell row, then
// the J/B update in the finish state, and is held in the output registers.
// Throughput: load and start words every cycle while idle; a residue word
// stalls the input until it has left the row and finished its J/B update.
// Reset clears row, J, B, halt flag, config registers, out_valid; not costs.
// ----------------------------------------------------------------------------
`default_nettype none

module msv_profile_score_filter_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [1:0] in_opcode,
  input  wire  [4:0] in_residue_code,
  input  wire  [7:0] in_position_index,
  input  wire  [7:0] in_cost_value,
  input  wire        in_last_residue,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_raw_j_score,
  output logic       out_overflow,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [2:0] cfg_index,
  input  wire  [8:0] cfg_data
);
  import msv_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_t;

  state_t     state_r;
  logic [8:0] model_length_r;
  logic [7:0] emission_bias_r;
  logic [7:0] score_base_r;
  logic [7:0] jb_cost_r;
  logic [7:0] bm_cost_r;
  logic [7:0] ec_cost_r;
  logic [7:0] j_r;
  logic [7:0] b_r;
  logic       halted_r;
  logic       last_r;
  logic [7:0] e_r;
  logic       out_valid_r;
  logic [7:0] out_score_r;
  logic       out_ovf_r;

  logic                 accept;
  logic [7:0]           tjbm;
  logic [LEN_CMP_W-1:0] len_ext;
  logic [LEN_W-1:0]     eff_len;
  logic                 res_ok;
  logic                 load_ok;
  logic [7:0]           e_bias;
  logic                 ovf;
  logic [7:0]           j_new;
  logic                 emit_need;
  logic                 finish_go;
  logic                 emit_go;
  msv_bcast_t           bcast;
  msv_token_t           tok [MAX_POSITIONS + 1];
  logic [MAX_POSITIONS-1:0] tok_valid_vec;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;

  assign tjbm    = 8'(jb_cost_r + bm_cost_r);
  assign len_ext = LEN_CMP_W'(model_length_r);
  assign eff_len = (len_ext > LEN_CMP_W'(MAX_POSITIONS)) ? LEN_W'(MAX_POSITIONS)
                                                        : LEN_W'(len_ext);
  assign res_ok  = RES_CMP_W'(in_residue_code) < RES_CMP_W'(ALPHABET_SIZE);
  assign load_ok = res_ok &&
                   (POS_CMP_W'(in_position_index) < POS_CMP_W'(MAX_POSITIONS));

  assign bcast.load    = accept && (in_opcode == OP_LOAD) && load_ok;
  assign bcast.clear   = accept && (in_opcode == OP_START);
  assign bcast.res_idx = RES_IDX_W'(in_residue_code);
  assign bcast.pos     = in_position_index;
  assign bcast.cost    = in_cost_value;
  assign bcast.bias    = emission_bias_r;
  assign bcast.eff_len = eff_len;

  // The residue word enters the first cell with an empty left neighbor.
  assign tok[0].valid   = accept && (in_opcode == OP_RESIDUE) && !halted_r;
  assign tok[0].res_ok  = res_ok;
  assign tok[0].res_idx = RES_IDX_W'(in_residue_code);
  assign tok[0].b       = b_r;
  assign tok[0].prev    = 8'd0;
  assign tok[0].emax    = 8'd0;

  for (genvar k = 0; k < MAX_POSITIONS; k++) begin : g_cell
    msv_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (POS_W'(k)),
      .bcast    (bcast),
      .tok_in   (tok[k]),
      .tok_out  (tok[k+1])
    );
    assign tok_valid_vec[k] = tok[k+1].valid;
  end

  assign e_bias    = add_sat(e_r, emission_bias_r);
  assign ovf       = (e_bias == SAT_MAX);
  assign j_new     = max8(j_r, sub_sat(e_r, ec_cost_r));
  assign emit_need = ovf || last_r;
  assign finish_go = !emit_need || !out_valid_r || !out_stall;
  assign emit_go   = (state_r == S_FINISH) && finish_go && emit_need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_length_r  <= 9'(MAX_POSITIONS);
      emission_bias_r <= 8'd0;
      score_base_r    <= 8'd0;
      jb_cost_r       <= 8'd0;
      bm_cost_r       <= 8'd0;
      ec_cost_r       <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODEL_LENGTH:  model_length_r  <= cfg_data;
        CFG_EMISSION_BIAS: emission_bias_r <= cfg_data[7:0];
        CFG_SCORE_BASE:    score_base_r    <= cfg_data[7:0];
        CFG_JB_COST:       jb_cost_r       <= cfg_data[7:0];
        CFG_BM_COST:       bm_cost_r       <= cfg_data[7:0];
        CFG_EC_COST:       ec_cost_r       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= 8'd0;
      b_r         <= 8'd0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_opcode == OP_START)) begin
            j_r      <= 8'd0;
            b_r      <= sub_sat(score_base_r, tjbm);
            halted_r <= 1'b0;
          end else if (tok[0].valid) begin
            last_r  <= in_last_residue;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok[MAX_POSITIONS].valid) begin
            e_r     <= tok[MAX_POSITIONS].emax;
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold here while an earlier result still waits at the output.
          if (finish_go) begin
            if (ovf) begin
              halted_r    <= 1'b1;
              out_score_r <= SAT_MAX;
              out_ovf_r   <= 1'b1;
            end else begin
              j_r <= j_new;
              b_r <= sub_sat(max8(score_base_r, j_new), tjbm);
              if (last_r) begin
                out_score_r <= j_new;
                out_ovf_r   <= 1'b0;
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_raw_j_score = out_score_r;
  assign out_overflow    = out_ovf_r;

  a_one_word_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one residue word in the cell row");

  a_tail_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tok[MAX_POSITIONS].valid |-> (state_r == S_RUN))
    else $error("residue word left the row outside the run state");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_raw_j_score) && $stable(out_overflow)))
    else $error("stalled result word changed or was dropped");

  a_row_empty_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (tok_valid_vec == '0))
    else $error("residue word in the row while idle");

endmodule

`default_nettype wire
